### rtl/msgd_pkg.sv
package msgd_pkg;

  // field and register widths
  localparam int X_W    = 16;
  localparam int W_W    = 32;
  localparam int LR_W   = 16;
  localparam int BS_W   = 11;
  localparam int ACC_W  = 60;
  localparam int ACC_XW = ACC_W + 1;
  localparam int FRAC_SHIFT = 12;
  localparam int Y_SHIFT    = 4;

  // datapath widths
  localparam int P1_W   = W_W + X_W;
  localparam int ERR_W  = P1_W - FRAC_SHIFT + 2;
  localparam int P2_W   = ERR_W + X_W;
  localparam int SACC_W = ACC_W + LR_W;
  localparam int R_W    = ACC_W + 2;

  // iteration counts of the batch-end sequence
  localparam int DIV_STEPS   = ACC_W;
  localparam int SCALE_STEPS = LR_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);

  // input commands
  localparam logic CMD_TRAIN  = 1'b0;
  localparam logic CMD_RELOAD = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [1:0] REG_BATCH_SIZE    = 2'd1;
  localparam logic [1:0] REG_INIT_WEIGHT0  = 2'd2;
  localparam logic [1:0] REG_INIT_WEIGHT1  = 2'd3;

  // register reset values
  localparam logic [LR_W-1:0]       LR_RESET = LR_W'(6554);
  localparam logic [BS_W-1:0]       BS_RESET = BS_W'(100);
  localparam logic signed [W_W-1:0] IW_RESET = W_W'(32768);

  // accumulator limits
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [W_W-1:0]   W_MAX   = {1'b0, {(W_W-1){1'b1}}};
  localparam logic signed [W_W-1:0]   W_MIN   = {1'b1, {(W_W-1){1'b0}}};

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic reload;
    logic prod;
    logic err;
    logic wprod;
    logic acc;
    logic div_init;
    logic div_step;
    logic scale_step;
    logic update;
  } msgd_cmd_t;

  // clip a grown sum back into the accumulator range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_XW-1:0] v);
    if (v[ACC_XW-1] != v[ACC_W-1]) begin
      sat_acc = v[ACC_XW-1] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_acc = v[ACC_W-1:0];
    end
  endfunction

endpackage

### rtl/msgd_ctrl.sv
module msgd_ctrl import msgd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_tuser,
  input  logic      in_tlast,
  output logic      in_tready,
  input  logic      out_tready,
  output logic      out_tvalid,
  output msgd_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_PROD  = 4'd2;
  localparam logic [3:0] ST_ERR   = 4'd3;
  localparam logic [3:0] ST_WPROD = 4'd4;
  localparam logic [3:0] ST_ACC   = 4'd5;
  localparam logic [3:0] ST_DINIT = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_SCALE = 4'd8;
  localparam logic [3:0] ST_UPD   = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_r, last_nxt;
  logic             ovalid_r, ovalid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    ovalid_nxt = ovalid_r && !out_tready;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          last_nxt    = in_tlast;
          state_nxt   = (in_tuser == CMD_RELOAD) ? ST_LOAD : ST_PROD;
        end
      end
      ST_LOAD: begin
        cmd.reload = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        cmd.err   = 1'b1;
        state_nxt = ST_WPROD;
      end
      ST_WPROD: begin
        cmd.wprod = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = last_r ? ST_DINIT : ST_IDLE;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCALE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SCALE: begin
        cmd.scale_step = 1'b1;
        if (cnt_r == CNT_W'(SCALE_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_UPD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_UPD: begin
        // wait until the output register is free
        if (!ovalid_r || out_tready) begin
          cmd.update = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      last_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      last_r   <= last_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

### rtl/msgd_dp.sv
module msgd_dp import msgd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  msgd_cmd_t             cmd,
  input  logic signed [X_W-1:0] x_in,
  input  logic signed [X_W-1:0] y_in,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [W_W-1:0]        cfg_wdata,
  output logic signed [W_W-1:0] weight0,
  output logic signed [W_W-1:0] weight1,
  output logic                  saturated
);

  // configuration
  logic [LR_W-1:0]       lr_r;
  logic [BS_W-1:0]       bs_r;
  logic signed [W_W-1:0] iw_r [2];

  // model state: lane 0 intercept / error sum, lane 1 slope / weighted sum
  logic signed [W_W-1:0]   w_r   [2];
  logic signed [ACC_W-1:0] sum_r [2];

  // per-sample pipeline registers
  logic signed [X_W-1:0]   x_r, y_r;
  logic signed [P1_W-1:0]  prod1_r;
  logic signed [ERR_W-1:0] err_r;
  logic signed [P2_W-1:0]  prod2_r;

  // batch-end divider and rate scaler
  logic [BS_W-1:0]   dsr_r;
  logic [LR_W-1:0]   lrs_r;
  logic [ACC_W-1:0]  dvd_r  [2];
  logic [BS_W-1:0]   rem_r  [2];
  logic              neg_r  [2];
  logic [SACC_W-1:0] sacc_r [2];

  // output payload
  logic signed [W_W-1:0] ow0_r, ow1_r;
  logic                  osat_r;

  logic signed [ERR_W-1:0] err_nxt;
  logic signed [ACC_W-1:0] sum_nxt [2];
  logic [ACC_W-1:0]        mag     [2];
  logic [BS_W:0]           trial   [2];
  logic                    qbit    [2];
  logic [BS_W-1:0]         rem_nxt [2];
  logic [ACC_W-1:0]        p       [2];
  logic signed [R_W-1:0]   step    [2];
  logic signed [R_W-1:0]   r       [2];
  logic                    clip    [2];
  logic signed [W_W-1:0]   w_new   [2];

  assign weight0   = ow0_r;
  assign weight1   = ow1_r;
  assign saturated = osat_r;

  // prediction error in Q22.16
  assign err_nxt = ERR_W'(w_r[0]) + ERR_W'(prod1_r >>> FRAC_SHIFT) - (ERR_W'(y_r) <<< Y_SHIFT);

  // saturating accumulation
  assign sum_nxt[0] = sat_acc(ACC_XW'(sum_r[0]) + ACC_XW'(err_r));
  assign sum_nxt[1] = sat_acc(ACC_XW'(sum_r[1]) + ACC_XW'(prod2_r >>> FRAC_SHIFT));

  // divider step, rate scaling result and weight update per lane
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mag[i]     = sum_r[i][ACC_W-1] ? (~sum_r[i] + 1'b1) : sum_r[i];
      trial[i]   = {rem_r[i], dvd_r[i][ACC_W-1]};
      qbit[i]    = (trial[i] >= {1'b0, dsr_r});
      rem_nxt[i] = qbit[i] ? BS_W'(trial[i] - {1'b0, dsr_r}) : trial[i][BS_W-1:0];
      p[i]       = sacc_r[i][SACC_W-1:LR_W];
      step[i]    = neg_r[i] ? -$signed({2'b00, p[i]}) : $signed({2'b00, p[i]});
      r[i]       = R_W'(w_r[i]) - step[i];
      clip[i]    = (r[i][R_W-1:W_W-1] != {(R_W-W_W+1){r[i][R_W-1]}});
      w_new[i]   = clip[i] ? (r[i][R_W-1] ? W_MIN : W_MAX) : r[i][W_W-1:0];
    end
  end

  // configuration registers and model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= LR_RESET;
      bs_r <= BS_RESET;
      for (int i = 0; i < 2; i++) begin
        iw_r[i]  <= IW_RESET;
        w_r[i]   <= '0;
        sum_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEARNING_RATE: lr_r    <= cfg_wdata[LR_W-1:0];
          REG_BATCH_SIZE:    bs_r    <= cfg_wdata[BS_W-1:0];
          REG_INIT_WEIGHT0:  iw_r[0] <= cfg_wdata;
          REG_INIT_WEIGHT1:  iw_r[1] <= cfg_wdata;
          default: begin
          end
        endcase
      end
      for (int i = 0; i < 2; i++) begin
        if (cmd.reload) begin
          w_r[i]   <= iw_r[i];
          sum_r[i] <= '0;
        end else if (cmd.update) begin
          w_r[i]   <= w_new[i];
          sum_r[i] <= '0;
        end else if (cmd.acc) begin
          sum_r[i] <= sum_nxt[i];
        end
      end
    end
  end

  // sample pipeline, divider, scaler and output payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r <= x_in;
      y_r <= y_in;
    end
    if (cmd.prod) begin
      prod1_r <= w_r[1] * x_r;
    end
    if (cmd.err) begin
      err_r <= err_nxt;
    end
    if (cmd.wprod) begin
      prod2_r <= err_r * x_r;
    end
    if (cmd.div_init) begin
      dsr_r <= (bs_r == '0) ? BS_W'(1) : bs_r;
      lrs_r <= lr_r;
    end else if (cmd.scale_step) begin
      lrs_r <= lrs_r << 1;
    end
    for (int i = 0; i < 2; i++) begin
      if (cmd.div_init) begin
        dvd_r[i]  <= mag[i];
        rem_r[i]  <= '0;
        neg_r[i]  <= sum_r[i][ACC_W-1];
        sacc_r[i] <= '0;
      end else if (cmd.div_step) begin
        dvd_r[i] <= {dvd_r[i][ACC_W-2:0], qbit[i]};
        rem_r[i] <= rem_nxt[i];
      end else if (cmd.scale_step) begin
        // shift-add over the rate bits, msb first
        sacc_r[i] <= (sacc_r[i] << 1) + (lrs_r[LR_W-1] ? SACC_W'(dvd_r[i]) : '0);
      end
    end
    if (cmd.update) begin
      ow0_r  <= w_new[0];
      ow1_r  <= w_new[1];
      osat_r <= clip[0] | clip[1];
    end
  end

endmodule

### rtl/minibatch_sgd_linear_fit.sv
// Mini-batch gradient-descent line fitter, y = weight0 + weight1 * x.
// Input channel in_*: one transaction per sample or command. in_tuser is the
// command (0 train, 1 reload initial weights), in_tlast marks the last sample
// of a batch, in_tdata carries x and y in Q4.12.
// Output channel out_*: one transaction per batch, carrying both new weights
// in Q16.16 and a flag in out_tuser that is set when either weight clipped.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_index
// (learning rate, batch size, initial weight0, initial weight1).
// Sequence: a training sample occupies the block through accept, slope
// product, error, weighted product and accumulate. A batch-end sample adds
// a divider setup step, a bit-serial divider, a shift-add rate scaler and
// an update step, after which the block returns to idle. A reload is
// accepted and then loads the initial weights before the block returns to
// idle. One item is in work at a time; in_tready is high while idle.
// The result sits in an output register, so intake continues while it waits
// for out_tready; only a second batch end stalls until the first is taken.
// Reset: configuration takes its default values, weights and sums clear and
// no result is pending.
module minibatch_sgd_linear_fit import msgd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // x_sample [15:0], y_target [31:16]
  input  logic        in_tuser,   // command
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // weight0 [31:0], weight1 [63:32]
  output logic        out_tuser,  // saturated
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  msgd_cmd_t             cmd;
  logic signed [W_W-1:0] weight0, weight1;

  msgd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  msgd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .x_in      (in_tdata[15:0]),
    .y_in      (in_tdata[31:16]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .weight0   (weight0),
    .weight1   (weight1),
    .saturated (out_tuser)
  );

  assign out_tdata = {weight1, weight0};

`ifndef SYNTHESIS
  // no result pending right after reset
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // a new result only appears while the block was busy with a batch end
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result raised while idle");

  // a reload transaction never produces a result
  a_reload_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> !$rose(out_tvalid))
    else $error("result after reload");

  // a sample not marked last returns to idle without a result
  a_train_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser && !in_tlast) |=> ##4 (in_tready && !$rose(out_tvalid)))
    else $error("training sample did not complete cleanly");
`endif

endmodule
